// ===== rtl/core/masd_pkg.sv =====
`timescale 1ns / 1ps

package masd_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned MAX_W    = 15;
  localparam int unsigned SD_W     = 16;
  // Squares of deviations fit in 32 bits, so the variance does too.
  localparam int unsigned SQ_W     = 32;
  localparam int unsigned MAG_W    = 17;
  localparam int unsigned MEAN_W   = 17;
  localparam int unsigned RT_REM_W = 18;
  localparam int unsigned RT_STEPS = 16;
  localparam int unsigned RT_CNT_W = 5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MEAN_GO,
    ST_MEAN,
    ST_PASS,
    ST_VAR,
    ST_ROOT,
    ST_DONE
  } state_t;

endpackage

// ===== rtl/core/masd_ram.sv =====
`timescale 1ns / 1ps

module masd_ram #(
  parameter int unsigned WIDTH  = 16,
  parameter int unsigned DEPTH  = 32,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/max_and_std_deviation.sv =====
`timescale 1ns / 1ps
// Samples are taken one per cycle, only while idle. After the last sample the
// block divides the sum by the count for the mean, sums the squared deviations
// of the stored samples, divides that by the count for the variance, takes the
// square root and loads the result. Both divisions share one bit-serial
// restoring divider. Synchronous reset clears the count, sum, maximum, overflow
// flag, state and result valid.
module max_and_std_deviation #(
  parameter int unsigned MAX_SAMPLES = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               sample_valid,
  output logic                               sample_ready,
  input  logic signed [masd_pkg::SAMPLE_W-1:0] sample,
  input  logic                               last_sample,
  output logic                               result_valid,
  input  logic                               result_ready,
  output logic [masd_pkg::MAX_W-1:0]         maximum,
  output logic [masd_pkg::SD_W-1:0]          std_deviation,
  output logic                               overflowed
);

  localparam int unsigned CW  = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned AW  = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int unsigned SW  = masd_pkg::SAMPLE_W + CW;
  localparam int unsigned QW  = masd_pkg::SQ_W + CW;
  localparam int unsigned DCW = $clog2(QW + 1);

  masd_pkg::state_t state, state_next;

  // Per-set accumulation
  logic [CW-1:0]                 count;
  logic signed [SW-1:0]          running_sum;
  logic [masd_pkg::MAX_W-1:0]    running_max;
  logic                          drop_flag;

  // Control
  logic accept, store_ok, div_start, div_sel_var, pass_init, root_start, out_load;

  // Shared divider
  logic [QW-1:0]  div_dvd;
  logic [CW-1:0]  div_rem;
  logic [DCW-1:0] div_left;
  logic [CW:0]    div_trial;
  logic           div_ge;
  logic [SW-1:0]  sum_abs;

  // Deviation pass
  logic signed [masd_pkg::MEAN_W-1:0] mean;
  logic [CW-1:0]                      rd_idx;
  logic                               rd_en;
  logic                               v1, v2, v3;
  logic [masd_pkg::SAMPLE_W-1:0]      rdata;
  logic signed [masd_pkg::MEAN_W:0]   diff;
  logic [masd_pkg::MAG_W-1:0]         mag;
  logic [2*masd_pkg::MAG_W-1:0]       prod;
  logic [masd_pkg::SQ_W-1:0]          sqr;
  logic [QW-1:0]                      sq_acc;
  logic                               pass_done;

  // Square root
  logic [masd_pkg::SQ_W-1:0]     rt_v;
  logic [masd_pkg::RT_REM_W-1:0] rt_rem;
  logic [masd_pkg::SD_W-1:0]     rt_root;
  logic [masd_pkg::RT_CNT_W-1:0] rt_left;
  logic [masd_pkg::RT_REM_W+1:0] rt_shift, rt_trial, rt_diff;

  assign accept   = sample_valid && sample_ready;
  assign store_ok = count < CW'(MAX_SAMPLES);

  masd_ram #(
    .WIDTH (masd_pkg::SAMPLE_W),
    .DEPTH (MAX_SAMPLES)
  ) u_store (
    .clk   (clk),
    .we    (accept && store_ok),
    .waddr (count[AW-1:0]),
    .wdata (sample),
    .re    (rd_en),
    .raddr (rd_idx[AW-1:0]),
    .rdata (rdata)
  );

  // ---------------------------------------------------------------- FSM
  assign pass_done = (rd_idx == count) && !v1 && !v2 && !v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= masd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    sample_ready = 1'b0;
    div_start    = 1'b0;
    div_sel_var  = 1'b0;
    pass_init    = 1'b0;
    root_start   = 1'b0;
    out_load     = 1'b0;
    unique case (state)
      masd_pkg::ST_IDLE: begin
        sample_ready = 1'b1;
        if (sample_valid && last_sample) begin
          state_next = masd_pkg::ST_MEAN_GO;
        end
      end
      masd_pkg::ST_MEAN_GO: begin
        div_start  = 1'b1;
        state_next = masd_pkg::ST_MEAN;
      end
      masd_pkg::ST_MEAN: begin
        if (div_left == '0) begin
          pass_init  = 1'b1;
          state_next = masd_pkg::ST_PASS;
        end
      end
      masd_pkg::ST_PASS: begin
        if (pass_done) begin
          div_start   = 1'b1;
          div_sel_var = 1'b1;
          state_next  = masd_pkg::ST_VAR;
        end
      end
      masd_pkg::ST_VAR: begin
        if (div_left == '0) begin
          root_start = 1'b1;
          state_next = masd_pkg::ST_ROOT;
        end
      end
      masd_pkg::ST_ROOT: begin
        if (rt_left == '0) begin
          state_next = masd_pkg::ST_DONE;
        end
      end
      masd_pkg::ST_DONE: begin
        if (!result_valid || result_ready) begin
          out_load   = 1'b1;
          state_next = masd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = masd_pkg::ST_IDLE;
      end
    endcase
  end

  // ------------------------------------------------------- accumulation
  always_ff @(posedge clk) begin
    if (rst || out_load) begin
      count       <= '0;
      running_sum <= '0;
      running_max <= '0;
      drop_flag   <= 1'b0;
    end else if (accept) begin
      if (store_ok) begin
        count       <= count + CW'(1);
        running_sum <= running_sum + {{(SW-masd_pkg::SAMPLE_W){sample[15]}}, sample};
        if (!sample[15] && (sample[14:0] > running_max)) begin
          running_max <= sample[14:0];
        end
      end else begin
        drop_flag <= 1'b1;
      end
    end
  end

  // ----------------------------------------------------- shared divider
  // Restoring division, one quotient bit a cycle; the quotient bits shift
  // in behind the dividend as it shifts out.
  assign sum_abs   = running_sum[SW-1] ? SW'(-running_sum) : SW'(running_sum);
  assign div_trial = {div_rem, div_dvd[QW-1]};
  assign div_ge    = div_trial >= {1'b0, count};

  always_ff @(posedge clk) begin
    if (rst) begin
      div_left <= '0;
    end else if (div_start) begin
      div_left <= DCW'(QW);
    end else if (div_left != '0) begin
      div_left <= div_left - DCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (div_start) begin
      div_rem <= '0;
      div_dvd <= div_sel_var ? sq_acc : {{(QW-SW){1'b0}}, sum_abs};
    end else if (div_left != '0) begin
      if (div_ge) begin
        div_rem <= CW'(div_trial - {1'b0, count});
      end else begin
        div_rem <= div_trial[CW-1:0];
      end
      div_dvd <= {div_dvd[QW-2:0], div_ge};
    end
  end

  // ----------------------------------------------------- deviation pass
  assign rd_en = (state == masd_pkg::ST_PASS) && (rd_idx != count);
  assign diff  = {rdata[15], rdata[15], rdata} - {mean[masd_pkg::MEAN_W-1], mean};
  assign prod  = mag * mag;

  always_ff @(posedge clk) begin
    if (pass_init) begin
      // Truncation toward zero: divide the magnitude, then restore the sign.
      mean <= running_sum[SW-1] ? -$signed(div_dvd[masd_pkg::MEAN_W-1:0])
                                : $signed(div_dvd[masd_pkg::MEAN_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx <= '0;
      v1     <= 1'b0;
      v2     <= 1'b0;
      v3     <= 1'b0;
    end else begin
      if (pass_init) begin
        rd_idx <= '0;
      end else if (rd_en) begin
        rd_idx <= rd_idx + CW'(1);
      end
      v1 <= rd_en;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (v1) begin
      mag <= diff[masd_pkg::MEAN_W] ? masd_pkg::MAG_W'(-diff)
                                    : diff[masd_pkg::MAG_W-1:0];
    end
    if (v2) begin
      sqr <= prod[masd_pkg::SQ_W-1:0];
    end
    if (pass_init) begin
      sq_acc <= '0;
    end else if (v3) begin
      sq_acc <= sq_acc + {{(QW-masd_pkg::SQ_W){1'b0}}, sqr};
    end
  end

  // -------------------------------------------------------- square root
  // Two radicand bits a cycle, most significant pair first.
  assign rt_shift = {rt_rem, rt_v[masd_pkg::SQ_W-1 -: 2]};
  assign rt_trial = {2'b00, rt_root, 2'b01};
  assign rt_diff  = rt_shift - rt_trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      rt_left <= '0;
    end else if (root_start) begin
      rt_left <= masd_pkg::RT_CNT_W'(masd_pkg::RT_STEPS);
    end else if (rt_left != '0) begin
      rt_left <= rt_left - masd_pkg::RT_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (root_start) begin
      rt_v    <= div_dvd[masd_pkg::SQ_W-1:0];
      rt_rem  <= '0;
      rt_root <= '0;
    end else if (rt_left != '0) begin
      rt_v <= {rt_v[masd_pkg::SQ_W-3:0], 2'b00};
      if (rt_shift >= rt_trial) begin
        rt_rem  <= rt_diff[masd_pkg::RT_REM_W-1:0];
        rt_root <= {rt_root[masd_pkg::SD_W-2:0], 1'b1};
      end else begin
        rt_rem  <= rt_shift[masd_pkg::RT_REM_W-1:0];
        rt_root <= {rt_root[masd_pkg::SD_W-2:0], 1'b0};
      end
    end
  end

  // ------------------------------------------------------------- result
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      maximum       <= running_max;
      std_deviation <= rt_root;
      overflowed    <= drop_flag;
    end
  end

endmodule

// ===== tb/max_and_std_deviation_test.sv =====
`timescale 1ns / 1ps

module max_and_std_deviation_test;

  localparam int unsigned STORE_DEPTH    = 32;
  localparam int unsigned ITEM_TARGET    = 1650;
  localparam int unsigned SETTLE_CYCLES  = 200;
  localparam int unsigned WATCHDOG_LIMIT = 5000;

  typedef struct packed {
    logic [masd_pkg::MAX_W-1:0] maximum;
    logic [masd_pkg::SD_W-1:0]  std_deviation;
    logic                       overflowed;
  } set_summary_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic sample_valid = 1'b0;
  logic sample_ready;
  logic signed [masd_pkg::SAMPLE_W-1:0] sample = '0;
  logic last_sample = 1'b0;
  logic result_valid;
  logic result_ready = 1'b0;
  logic [masd_pkg::MAX_W-1:0] maximum;
  logic [masd_pkg::SD_W-1:0] std_deviation;
  logic overflowed;

  // Mirror of the block's accumulation state.
  logic signed [masd_pkg::SAMPLE_W-1:0] held_samples [STORE_DEPTH];
  int unsigned held_count = 0;
  longint held_sum = 0;
  int held_max = 0;
  logic samples_dropped = 1'b0;

  set_summary_t pending_summaries [$];
  int fail_count = 0;
  int items_sent = 0;
  int burst_left = 0;
  int idle_cycles = 0;
  int ready_mode = 0;
  int ready_mode_age = 0;

  always #2 clk = ~clk;

  max_and_std_deviation u_top (
    .clk           (clk),
    .rst           (rst),
    .sample_valid  (sample_valid),
    .sample_ready  (sample_ready),
    .sample        (sample),
    .last_sample   (last_sample),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .maximum       (maximum),
    .std_deviation (std_deviation),
    .overflowed    (overflowed)
  );

  function automatic logic [31:0] floor_sqrt(input logic [63:0] v);
    logic [31:0] root;
    logic [63:0] trial;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = {32'd0, root | (32'd1 << b)};
      if (trial * trial <= v) begin
        root = root | (32'd1 << b);
      end
    end
    return root;
  endfunction

  // Takes one accepted request into the mirrored state and, on the last
  // sample of a set, queues the summary that the block should return.
  function automatic void accumulate_sample(input logic signed [masd_pkg::SAMPLE_W-1:0] s,
                                            input logic is_last);
    longint mean;
    longint dev;
    longint sq_total;
    set_summary_t summary;
    if (held_count < STORE_DEPTH) begin
      held_samples[held_count] = s;
      held_count++;
      held_sum += longint'(s);
      if (int'(s) > held_max) begin
        held_max = int'(s);
      end
    end else begin
      samples_dropped = 1'b1;
    end
    if (is_last) begin
      summary.std_deviation = '0;
      if (held_count != 0) begin
        // Signed division truncates toward zero, as the block's mean does.
        mean = held_sum / longint'(held_count);
        sq_total = 0;
        for (int i = 0; i < held_count; i++) begin
          dev = longint'(held_samples[i]) - mean;
          sq_total += dev * dev;
        end
        summary.std_deviation =
          masd_pkg::SD_W'(floor_sqrt(64'(sq_total / longint'(held_count))));
      end
      summary.maximum = masd_pkg::MAX_W'(held_max);
      summary.overflowed = samples_dropped;
      pending_summaries.push_back(summary);
      held_count = 0;
      held_sum = 0;
      held_max = 0;
      samples_dropped = 1'b0;
    end
  endfunction

  task automatic send_sample(input logic signed [masd_pkg::SAMPLE_W-1:0] s,
                             input logic is_last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        sample_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    sample_valid <= 1'b1;
    sample <= s;
    last_sample <= is_last;
    @(posedge clk);
    while (!(sample_valid && sample_ready)) @(posedge clk);
    accumulate_sample(s, is_last);
    items_sent++;
  endtask

  // Holds the sender off until every outstanding summary has come back.
  task automatic wait_all_results();
    sample_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_summaries.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [masd_pkg::SAMPLE_W-1:0] pick_sample(input int value_mode);
    case (value_mode)
      0: pick_sample = masd_pkg::SAMPLE_W'($urandom_range(0, 1023)) - 16'sd512;
      1: pick_sample = $urandom_range(0, 1)
                       ? 16'sh7fff - masd_pkg::SAMPLE_W'($urandom_range(0, 3))
                       : 16'sh8000 + masd_pkg::SAMPLE_W'($urandom_range(0, 3));
      2: pick_sample = -masd_pkg::SAMPLE_W'($urandom_range(1, 32768));
      default: pick_sample = masd_pkg::SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic test_single_sample_sets();
    send_sample(16'sh7fff, 1'b1);
    send_sample(16'sh8000, 1'b1);
    send_sample(16'sh0000, 1'b1);
    send_sample(16'sh0180, 1'b1);
    wait_all_results();
  endtask

  task automatic test_extreme_values();
    // Widest possible spread, a set wholly below zero, a small positive set, a mixed-sign pair.
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh8000, 1'b1);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh8000, 1'b1);
    send_sample(-16'sd1, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(-16'sd300, 1'b1);
    send_sample(16'sd5, 1'b0);
    send_sample(16'sd7, 1'b0);
    send_sample(16'sd9, 1'b1);
    send_sample(16'sh5555, 1'b0);
    send_sample(16'shaaaa, 1'b1);
    wait_all_results();
  endtask

  task automatic test_full_store();
    // Exactly full, then full with a dropped last sample, then drops mid-set.
    for (int i = 0; i < STORE_DEPTH; i++) begin
      send_sample(pick_sample(3), i == STORE_DEPTH - 1);
    end
    for (int i = 0; i < STORE_DEPTH + 1; i++) begin
      send_sample((i % 2 == 0) ? 16'sh7fff : 16'sh8000, i == STORE_DEPTH);
    end
    for (int i = 0; i < STORE_DEPTH + 4; i++) begin
      send_sample(pick_sample(0), i == STORE_DEPTH + 3);
    end
    wait_all_results();
  endtask

  task automatic test_random_sets();
    int set_len;
    int value_mode;
    int set_kind;
    logic signed [masd_pkg::SAMPLE_W-1:0] repeated;
    while (items_sent < ITEM_TARGET) begin
      set_kind = $urandom_range(0, 19);
      if (set_kind < 10) begin
        set_len = $urandom_range(1, 8);
      end else if (set_kind < 16) begin
        set_len = $urandom_range(1, STORE_DEPTH);
      end else if (set_kind < 18) begin
        set_len = STORE_DEPTH;
      end else begin
        set_len = $urandom_range(STORE_DEPTH + 1, STORE_DEPTH + 8);
      end
      value_mode = $urandom_range(0, 4);
      repeated = pick_sample(3);
      for (int i = 0; i < set_len; i++) begin
        // Mode four repeats one value, so the deviation must come out as zero.
        send_sample((value_mode == 4) ? repeated : pick_sample(value_mode), i == set_len - 1);
      end
      if ($urandom_range(0, 15) == 0) begin
        wait_all_results();
      end
    end
    wait_all_results();
  endtask

  // The receiver changes its stalling habit every so often.
  always @(posedge clk) begin
    if (ready_mode_age == 0) begin
      ready_mode = $urandom_range(0, 3);
      ready_mode_age <= $urandom_range(50, 400);
    end else begin
      ready_mode_age <= ready_mode_age - 1;
    end
    case (ready_mode)
      0: result_ready <= 1'b1;
      1: result_ready <= $urandom_range(0, 1);
      2: result_ready <= ($urandom_range(0, 3) == 0);
      default: result_ready <= ($urandom_range(0, 31) == 0);
    endcase
  end

  always @(posedge clk) begin
    set_summary_t want;
    if (!rst && result_valid && result_ready) begin
      if (pending_summaries.size() == 0) begin
        $error("result with none expected: maximum %0d std_deviation %0d overflowed %0d",
               maximum, std_deviation, overflowed);
        fail_count++;
      end else begin
        want = pending_summaries.pop_front();
        if (maximum !== want.maximum) begin
          $error("maximum: expected %0d, got %0d", want.maximum, maximum);
          fail_count++;
        end
        if (std_deviation !== want.std_deviation) begin
          $error("std_deviation: expected %0d, got %0d", want.std_deviation, std_deviation);
          fail_count++;
        end
        if (overflowed !== want.overflowed) begin
          $error("overflowed: expected %0d, got %0d", want.overflowed, overflowed);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (sample_valid && sample_ready) || (result_valid && result_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("max_and_std_deviation_test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_single_sample_sets();
    test_extreme_values();
    test_full_store();
    test_random_sets();
    if (fail_count == 0 && pending_summaries.size() == 0) begin
      $display("max_and_std_deviation_test passed");
    end else begin
      $display("max_and_std_deviation_test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/masd_pkg.sv
rtl/core/masd_ram.sv
rtl/core/max_and_std_deviation.sv
tb/max_and_std_deviation_test.sv
